// ===== rtl/laacs_pkg.sv =====
// Package for the local alignment affine cell scorer.
// Holds score types, the minus-infinity code, trace codes and the saturating add.
// No dependencies; imported by laacs_cell, local_align_affine_cell_scorer and the testbench.
package laacs_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CNT_W  = 11;    // row_count / col_count register width
    localparam int IN_W   = 128;   // eight 16-bit scores
    localparam int OUT_W  = 48;    // packed result word
    localparam int POS_W  = 10;    // reported row / column width

    typedef logic signed [23:0] t_score;
    typedef logic signed [15:0] t_in_score;

    localparam t_score NEG_INF = 24'sh800000;
    localparam t_score POS_MAX = 24'sh7FFFFF;
    localparam logic [POS_W-1:0] BEST_NONE = 10'h3FF;

    // Match source codes
    localparam logic [1:0] SRC_MATCH  = 2'd0;
    localparam logic [1:0] SRC_DELETE = 2'd1;
    localparam logic [1:0] SRC_INSERT = 2'd2;
    localparam logic [1:0] SRC_START  = 2'd3;

    // Configuration register indexes (paddr[2])
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Input word, first field in the highest bits
    typedef struct packed {
        t_in_score ii;
        t_in_score mi;
        t_in_score dd;
        t_in_score md;
        t_in_score sub;
        t_in_score im;
        t_in_score dm;
        t_in_score mm;
    } t_scores;

    // One entry of the row memory: previous-row match and delete values
    typedef struct packed {
        t_score match;
        t_score del;
    } t_row_pair;

    typedef struct packed {
        logic [1:0] src;
        logic       dext;
        logic       iopen;
    } t_trace;

    // Saturating add; minus infinity absorbs
    function automatic t_score sat_add(input t_score a, input t_in_score b);
        logic signed [24:0] s;
        begin
            s = $signed({a[23], a}) + $signed({{9{b[15]}}, b});
            if (a == NEG_INF) begin
                return NEG_INF;
            end
            if (s[24] != s[23]) begin
                return s[24] ? NEG_INF : POS_MAX;
            end
            return t_score'(s);
        end
    endfunction

endpackage

// ===== rtl/local_align_affine_cell_scorer.sv =====
// Top level of the affine-gap local alignment cell scorer.
// Holds the row memory, index control, best tracking and the APB registers.
// Depends on laacs_pkg and laacs_cell.
//
//  Port group    Dir  Content
//  ----------    ---  -----------------------------------------------------
//  i_s_*         in   one cell word: eight Q7.8 scores, row-major order
//  o_m_*         out  one result word per cell; tlast on the final cell
//  APB (i_p*)    in   row_count at 0x0, col_count at 0x4
//
// One cell per cycle sustained while result words are taken. An accepted
// word loads stage A with its row memory read, stage B then takes the cell
// add/compare result, and the output register then takes the best-score
// update. No clearing pass after reset: a fill count marks the columns
// written so far, and columns beyond it read as minus infinity.
// Stages collapse bubbles; o_s_tready drops only when every stage is full
// and the output word is not taken.
module local_align_affine_cell_scorer #(
    parameter int MAX_COLS = laacs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = laacs_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // score_match_to_match, score_delete_to_match, score_insert_to_match,
    // score_substitution, score_match_to_delete, score_delete_to_delete,
    // score_match_to_insert, score_insert_to_insert (16 bits each, low first)
    input  logic [laacs_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // match_source[1:0], delete_extends[2], insert_opens[3], best_score[26:4],
    // best_row[36:27], best_col[46:37], found[47]
    output logic [laacs_pkg::OUT_W-1:0] o_m_tdata,
    output logic                        o_m_tlast,     // matrix_done
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [2:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);
    import laacs_pkg::*;

    localparam int CAW = $clog2(MAX_COLS);        // column address
    localparam int CW  = $clog2(MAX_COLS + 1);    // holds MAX_COLS
    localparam int CW1 = CW + 1;
    localparam int RAW = $clog2(MAX_ROWS);        // row index
    localparam int RW  = $clog2(MAX_ROWS + 1);    // holds MAX_ROWS
    localparam int XCW = (CW > CNT_W) ? CW : CNT_W;
    localparam int XRW = (RW > CNT_W) ? RW : CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_row_count, r_col_count;
    logic             cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_W'(1);
            r_col_count <= CNT_W'(1);
        end else if (cfg_wr) begin
            case (i_paddr[2])
                REG_ROW_COUNT: r_row_count <= i_pwdata[CNT_W-1:0];
                REG_COL_COUNT: r_col_count <= i_pwdata[CNT_W-1:0];
                default:       r_row_count <= r_row_count;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_ROW_COUNT: o_prdata = 32'(r_row_count);
            REG_COL_COUNT: o_prdata = 32'(r_col_count);
            default:       o_prdata = '0;
        endcase
    end

    // Clamp counts: zero acts as one, above the maximum acts as the maximum
    logic [XCW-1:0] cnt_c_x;
    logic [XRW-1:0] cnt_r_x;
    logic [CW-1:0]  eff_cols;
    logic [RW-1:0]  eff_rows;

    assign cnt_c_x  = XCW'(r_col_count);
    assign cnt_r_x  = XRW'(r_row_count);
    assign eff_cols = (cnt_c_x == '0) ? CW'(1) :
                      (cnt_c_x > XCW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cnt_c_x);
    assign eff_rows = (cnt_r_x == '0) ? RW'(1) :
                      (cnt_r_x > XRW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cnt_r_x);

    // ------------------------------------------------------------------
    // Handshake across the three stages
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_out_valid;
    logic out_free, b_free, a_free, a_go, b_go, in_acc;

    assign out_free   = !r_out_valid || i_m_tready;
    assign b_go       = r_b_valid && out_free;
    assign b_free     = !r_b_valid || out_free;
    assign a_go       = r_a_valid && b_free;
    assign a_free     = !r_a_valid || b_free;
    assign o_s_tready = a_free;
    assign in_acc     = i_s_tvalid && a_free;

    // ------------------------------------------------------------------
    // Cell index: wrap on shrunk counts, then step to the next cell
    // ------------------------------------------------------------------
    logic [CAW-1:0] r_col_idx, n_col_idx, cur_col;
    logic [RAW-1:0] r_row_idx, n_row_idx, cur_row;
    logic [CW-1:0]  col_inc;
    logic [RW-1:0]  row_w, row_inc;
    logic           wrap_c, cur_done;

    always_comb begin
        wrap_c   = CW'(r_col_idx) >= eff_cols;
        cur_col  = wrap_c ? '0 : r_col_idx;
        row_w    = wrap_c ? RW'(r_row_idx) + RW'(1) : RW'(r_row_idx);
        cur_row  = (row_w >= eff_rows) ? '0 : RAW'(row_w);
        col_inc  = CW'(cur_col) + CW'(1);
        row_inc  = RW'(cur_row) + RW'(1);
        cur_done = (col_inc == eff_cols) && (row_inc == eff_rows);
        if (col_inc >= eff_cols) begin
            n_col_idx = '0;
            n_row_idx = (row_inc >= eff_rows) ? '0 : RAW'(row_inc);
        end else begin
            n_col_idx = CAW'(col_inc);
            n_row_idx = cur_row;
        end
    end

    // ------------------------------------------------------------------
    // Row memory: entry c holds match_row[c+1] and delete_row[c]
    // ------------------------------------------------------------------
    t_row_pair      r_row_mem [MAX_COLS];
    t_row_pair      r_rd_data, r_fwd_data, wr_pair, rd_pair;
    logic           r_rd_ok, r_fwd;
    logic [CW-1:0]  r_fill;

    // Stage A payload
    t_scores        r_a_scores;
    logic [CAW-1:0] r_a_col;
    logic [RAW-1:0] r_a_row;
    logic           r_a_done;

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_row_mem[r_a_col] <= wr_pair;
        end
        if (in_acc) begin
            r_rd_data <= r_row_mem[cur_col];
        end
    end

    // Forward the word written in the same cycle as a read of that column
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_scores <= t_scores'(i_s_tdata);
            r_a_col    <= cur_col;
            r_a_row    <= cur_row;
            r_a_done   <= cur_done;
            r_rd_ok    <= CW'(cur_col) < r_fill;
            r_fwd      <= a_go && (r_a_col == cur_col);
            r_fwd_data <= wr_pair;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: cell arithmetic, row write-back, running insert / diagonal
    // ------------------------------------------------------------------
    t_score   r_ins, r_diag;
    t_score   diag_in, ins_in, saved, dprev;
    t_score   cell_m, cell_d, cell_i;
    t_trace   cell_tr;
    logic     first_row, row_start;

    always_comb begin
        rd_pair   = r_fwd ? r_fwd_data :
                    (r_rd_ok ? r_rd_data : t_row_pair'{match: NEG_INF, del: NEG_INF});
        first_row = (r_a_row == '0);
        row_start = (r_a_col == '0);
        saved     = first_row ? NEG_INF : rd_pair.match;
        dprev     = first_row ? NEG_INF : rd_pair.del;
        diag_in   = row_start ? NEG_INF : r_diag;
        ins_in    = row_start ? NEG_INF : r_ins;
        wr_pair   = '{match: cell_m, del: cell_d};
    end

    laacs_cell u_cell (
        .i_scores (r_a_scores),
        .i_diag   (diag_in),
        .i_dprev  (dprev),
        .i_ins    (ins_in),
        .o_match  (cell_m),
        .o_delete (cell_d),
        .o_insert (cell_i),
        .o_trace  (cell_tr)
    );

    // Report only the low ten bits of the cell indexes
    logic [RAW+POS_W-1:0] row_ext;
    logic [CAW+POS_W-1:0] col_ext;

    assign row_ext = {{POS_W{1'b0}}, r_a_row};
    assign col_ext = {{POS_W{1'b0}}, r_a_col};

    // Stage B payload
    t_trace           r_b_trace;
    t_score           r_b_match;
    logic [POS_W-1:0] r_b_row, r_b_col;
    logic             r_b_new_mat, r_b_done;

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_trace   <= cell_tr;
            r_b_match   <= cell_m;
            r_b_row     <= row_ext[POS_W-1:0];
            r_b_col     <= col_ext[POS_W-1:0];
            r_b_new_mat <= first_row && row_start;
            r_b_done    <= r_a_done;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: running best, restarted on the first cell of a matrix
    // ------------------------------------------------------------------
    logic [22:0]      r_best_val, base_val, nb_val;
    logic [POS_W-1:0] r_best_row, r_best_col, base_row, base_col, nb_row, nb_col;
    logic             take;

    always_comb begin
        base_val = r_b_new_mat ? '0 : r_best_val;
        base_row = r_b_new_mat ? BEST_NONE : r_best_row;
        base_col = r_b_new_mat ? BEST_NONE : r_best_col;
        // old best wins a tie
        take     = $signed(r_b_match) > $signed({1'b0, base_val});
        nb_val   = take ? r_b_match[22:0] : base_val;
        nb_row   = take ? r_b_row : base_row;
        nb_col   = take ? r_b_col : base_col;
    end

    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_out_data <= {(nb_val != '0), nb_col, nb_row, nb_val,
                           r_b_trace.iopen, r_b_trace.dext, r_b_trace.src};
            r_out_last <= r_b_done;
        end
    end

    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tvalid = r_out_valid;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_col_idx   <= '0;
            r_row_idx   <= '0;
            r_fill      <= '0;
            r_ins       <= NEG_INF;
            r_diag      <= NEG_INF;
            r_best_val  <= '0;
            r_best_row  <= BEST_NONE;
            r_best_col  <= BEST_NONE;
        end else begin
            if (a_free) begin
                r_a_valid <= i_s_tvalid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
            if (in_acc) begin
                r_col_idx <= n_col_idx;
                r_row_idx <= n_row_idx;
            end
            if (a_go) begin
                r_ins  <= cell_i;
                r_diag <= saved;
                // written columns always form a prefix; grow it by one
                if (CW'(r_a_col) == r_fill) begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (b_go) begin
                r_best_val <= nb_val;
                r_best_row <= nb_row;
                r_best_col <= nb_col;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // no best position is reported unless a positive score was found
    a_none_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[47]) |->
            (o_m_tdata[36:27] == BEST_NONE && o_m_tdata[46:37] == BEST_NONE))
        else $error("best position set without a positive best score");

    // a read can meet a same-cycle write of its column only with one column
    a_fwd_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && a_go && (r_a_col == cur_col)) |-> (cur_col == '0))
        else $error("unexpected read/write collision in row memory");

    // a new cell never reads past the written prefix plus the pending write
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (CW1'(cur_col) <= CW1'(r_fill) + CW1'(r_a_valid)))
        else $error("cell column beyond the row memory fill count");

endmodule

// ===== rtl/laacs_cell.sv =====
// Cell arithmetic of the affine-gap local alignment scorer.
// Forms match, delete and insert values plus trace bits for one cell.
// Depends on laacs_pkg.
module laacs_cell (
    input  laacs_pkg::t_scores  i_scores,
    input  laacs_pkg::t_score   i_diag,
    input  laacs_pkg::t_score   i_dprev,
    input  laacs_pkg::t_score   i_ins,
    output laacs_pkg::t_score   o_match,
    output laacs_pkg::t_score   o_delete,
    output laacs_pkg::t_score   o_insert,
    output laacs_pkg::t_trace   o_trace
);
    import laacs_pkg::*;

    t_score mm, dm, im, md, dd, mi, ii, best_in;

    always_comb begin
        mm = sat_add(i_diag,  i_scores.mm);
        dm = sat_add(i_dprev, i_scores.dm);
        im = sat_add(i_ins,   i_scores.im);
        md = sat_add(i_diag,  i_scores.md);
        dd = sat_add(i_dprev, i_scores.dd);
        mi = sat_add(i_diag,  i_scores.mi);
        ii = sat_add(i_ins,   i_scores.ii);

        // match: earliest candidate wins ties, then floor at zero
        best_in = mm;
        o_trace.src = SRC_MATCH;
        if ($signed(dm) > $signed(best_in)) begin
            best_in = dm;
            o_trace.src = SRC_DELETE;
        end
        if ($signed(im) > $signed(best_in)) begin
            best_in = im;
            o_trace.src = SRC_INSERT;
        end
        if (best_in[23]) begin
            best_in = '0;
            o_trace.src = SRC_START;
        end
        o_match = sat_add(best_in, i_scores.sub);

        o_trace.dext = $signed(dd) > $signed(md);
        o_delete     = o_trace.dext ? dd : md;

        o_trace.iopen = $signed(mi) > $signed(ii);
        o_insert      = o_trace.iopen ? mi : ii;
    end

endmodule

// ===== tb/laacs_result_checker.sv =====
// Scoreboard for the affine-gap local alignment cell scorer.
// Watches the score, result and APB channels, predicts every result word and compares it.
// Depends on laacs_pkg.
module laacs_result_checker #(
    parameter int MAX_COLS = laacs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = laacs_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [laacs_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [laacs_pkg::OUT_W-1:0] i_m_tdata,
    input  logic                        i_m_tlast,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [2:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_pending,
    output int                          o_errors
);
    import laacs_pkg::*;

    localparam int SCORE_FLOOR = NEG_INF;
    localparam int SCORE_CEIL  = POS_MAX;

    // Result word as it leaves the block, matrix_done from tlast on top
    typedef struct packed {
        logic             done;
        logic             found;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [22:0]      best;
        logic             iopen;
        logic             dext;
        logic [1:0]       src;
    } t_cell_result;

    int               match_prev [0:MAX_COLS];
    int               delete_prev[0:MAX_COLS];
    int               insert_run;
    int               diag_run;
    int               best_val;
    logic [POS_W-1:0] best_row_q;
    logic [POS_W-1:0] best_col_q;
    int               row_at;
    int               col_at;
    logic [CNT_W-1:0] rows_reg;
    logic [CNT_W-1:0] cols_reg;
    t_cell_result     expected_results[$];
    int               mismatch_count;

    function automatic int sat_sum(input int acc, input int delta);
        int s;
        if (acc == SCORE_FLOOR) begin
            return SCORE_FLOOR;
        end
        s = acc + delta;
        if (s > SCORE_CEIL) begin
            s = SCORE_CEIL;
        end
        if (s < SCORE_FLOOR) begin
            s = SCORE_FLOOR;
        end
        return s;
    endfunction

    function automatic int clamp_count(input logic [CNT_W-1:0] v, input int limit);
        if (v == 0) begin
            return 1;
        end
        if (int'(v) > limit) begin
            return limit;
        end
        return int'(v);
    endfunction

    // Advance the alignment state by one cell and return its result word
    function automatic t_cell_result score_cell(input t_scores w);
        int rows, cols, r, c;
        int saved, dprev, via_m, via_d, via_i, pre, m;
        int open_d, ext_d, open_i, ext_i;
        t_cell_result res;
        rows = clamp_count(rows_reg, MAX_ROWS);
        cols = clamp_count(cols_reg, MAX_COLS);
        r = row_at;
        c = col_at;
        res = '0;
        // indices left past a count that shrank wrap forward
        if (c >= cols) begin
            c = 0;
            r++;
        end
        if (r >= rows) begin
            r = 0;
        end
        if (c == 0) begin
            insert_run = SCORE_FLOOR;
            diag_run = SCORE_FLOOR;
        end
        if (r == 0 && c == 0) begin
            best_val = 0;
            best_row_q = BEST_NONE;
            best_col_q = BEST_NONE;
        end
        saved = (r == 0) ? SCORE_FLOOR : match_prev[c + 1];
        dprev = (r == 0) ? SCORE_FLOOR : delete_prev[c];

        via_m = sat_sum(diag_run, w.mm);
        via_d = sat_sum(dprev, w.dm);
        via_i = sat_sum(insert_run, w.im);
        pre = via_m;
        res.src = SRC_MATCH;
        if (via_d > pre) begin
            pre = via_d;
            res.src = SRC_DELETE;
        end
        if (via_i > pre) begin
            pre = via_i;
            res.src = SRC_INSERT;
        end
        if (pre < 0) begin
            pre = 0;
            res.src = SRC_START;
        end
        m = sat_sum(pre, w.sub);
        if (m > best_val) begin
            best_val = m;
            best_row_q = POS_W'(r);
            best_col_q = POS_W'(c);
        end
        match_prev[c + 1] = m;

        open_d = sat_sum(diag_run, w.md);
        ext_d = sat_sum(dprev, w.dd);
        res.dext = (ext_d > open_d);
        delete_prev[c] = res.dext ? ext_d : open_d;

        open_i = sat_sum(diag_run, w.mi);
        ext_i = sat_sum(insert_run, w.ii);
        res.iopen = (open_i > ext_i);
        insert_run = res.iopen ? open_i : ext_i;
        diag_run = saved;

        res.done = (r + 1 == rows) && (c + 1 == cols);
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) begin
                r = 0;
            end
        end
        row_at = r;
        col_at = c;

        res.best = 23'(best_val);
        res.row = best_row_q;
        res.col = best_col_q;
        res.found = (best_val > 0);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [22:0] want,
                               input logic [22:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cell_result want;
        t_cell_result got;
        if (!i_rst_n) begin
            for (int k = 0; k <= MAX_COLS; k++) begin
                match_prev[k] = SCORE_FLOOR;
                delete_prev[k] = SCORE_FLOOR;
            end
            insert_run = SCORE_FLOOR;
            diag_run = SCORE_FLOOR;
            best_val = 0;
            best_row_q = BEST_NONE;
            best_col_q = BEST_NONE;
            row_at = 0;
            col_at = 0;
            rows_reg = 1;
            cols_reg = 1;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_ROW_COUNT) begin
                    rows_reg = i_pwdata[CNT_W-1:0];
                end else begin
                    cols_reg = i_pwdata[CNT_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(score_cell(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tlast, i_m_tdata};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with nothing expected, actual 0x%0h",
                             $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("match_source",   23'(want.src),   23'(got.src));
                    check_field("delete_extends", 23'(want.dext),  23'(got.dext));
                    check_field("insert_opens",   23'(want.iopen), 23'(got.iopen));
                    check_field("best_score",     want.best,       got.best);
                    check_field("best_row",       23'(want.row),   23'(got.row));
                    check_field("best_col",       23'(want.col),   23'(got.col));
                    check_field("found",          23'(want.found), 23'(got.found));
                    check_field("matrix_done",    23'(want.done),  23'(got.done));
                end
            end
        end
        o_pending <= expected_results.size();
        o_errors <= mismatch_count;
    end

endmodule

// ===== tb/tb_local_align_affine_cell_scorer.sv =====
// Testbench top for the affine-gap local alignment cell scorer.
// Drives score words and APB writes with random stalls; laacs_result_checker predicts
// and compares. Depends on laacs_pkg, laacs_result_checker and the scorer RTL.
module tb_local_align_affine_cell_scorer;
    import laacs_pkg::*;

    localparam int TOTAL_CELLS  = 1950;  // score words to send in the whole run
    localparam int BIG_CELLS    = 1030;  // one full 1024-wide row plus a bit of the next
    localparam int DRAIN_CYCLES = 8;     // idle margin after the last result word

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic [IN_W-1:0]   i_s_tdata  = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [OUT_W-1:0]  o_m_tdata;
    logic              o_m_tlast;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic              i_psel     = 1'b0;
    logic              i_penable  = 1'b0;
    logic              i_pwrite   = 1'b0;
    logic [2:0]        i_paddr    = '0;
    logic [31:0]       i_pwdata   = '0;
    logic [31:0]       o_prdata;
    logic              o_pready;

    int words_in_flight;
    int mismatches;
    int cells_sent = 0;
    // 0: sender stalls lightly, receiver heavily; 1: the reverse; 2: no stalls
    int idle_phase = 0;

    local_align_affine_cell_scorer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    laacs_result_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tlast  (o_m_tlast),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .i_pready   (o_pready),
        .o_pending  (words_in_flight),
        .o_errors   (mismatches)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side backpressure; redraw tready every cycle by the current stall mix
    always @(posedge i_clk) begin
        case (idle_phase)
            0:       i_m_tready <= ($urandom_range(99) >= 85);
            1:       i_m_tready <= ($urandom_range(99) >= 21);
            default: i_m_tready <= 1'b1;
        endcase
    end

    // Directed score words: saturating extremes, all-equal ties and a max/min mix
    function automatic t_scores pattern_scores(input int k);
        t_scores scores;
        case (k % 5)
            0:       scores = {8{16'h7FFF}};
            1:       scores = {8{16'h8000}};
            2:       scores = '0;
            3:       scores = {4{16'h8000, 16'h7FFF}};
            default: scores = {8{16'h0100}};
        endcase
        return scores;
    endfunction

    // Mix narrow values (frequent ties), mid-range, full-range and extreme scores
    function automatic t_in_score random_score();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) begin
            return t_in_score'($urandom_range(8) - 4);
        end
        if (roll < 60) begin
            return t_in_score'($urandom_range(4096) - 2048);
        end
        if (roll < 85) begin
            return t_in_score'($urandom());
        end
        case ($urandom_range(3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic t_scores random_scores();
        t_scores scores;
        scores.mm  = random_score();
        scores.dm  = random_score();
        scores.im  = random_score();
        scores.sub = random_score();
        scores.md  = random_score();
        scores.dd  = random_score();
        scores.mi  = random_score();
        scores.ii  = random_score();
        return scores;
    endfunction

    // Mostly small matrices, now and then wide ones, zero and out-of-range counts
    function automatic logic [CNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            return CNT_W'($urandom_range(1, 8));
        end
        if (roll < 80) begin
            return CNT_W'($urandom_range(9, 40));
        end
        if (roll < 90) begin
            return CNT_W'($urandom_range(1));
        end
        return CNT_W'($urandom_range(1024, 2047));
    endfunction

    // Offer one score word, with random gaps first, and hold it until taken
    task automatic push_scores(input t_scores scores);
        int hold_pct;
        hold_pct = (idle_phase == 0) ? 21 : (idle_phase == 1) ? 85 : 0;
        if ($urandom_range(99) < hold_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < hold_pct);
        end
        i_s_tdata <= scores;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        cells_sent++;
        idle_phase = (cells_sent * 3) / TOTAL_CELLS;
        if (idle_phase > 2) begin
            idle_phase = 2;
        end
    endtask

    // Stop sending and wait until every predicted word has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (words_in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready; garbage above the count bits
    task automatic write_reg(input logic reg_sel, input logic [CNT_W-1:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {reg_sel, 2'b00};
        i_pwdata <= {21'($urandom()), value};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] rows_val;
        logic [CNT_W-1:0] cols_val;
        int rows_eff;
        int cols_eff;
        int area;
        int burst;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Counts reset to one by one: every word is a whole matrix of its own
        push_scores(pattern_scores(2));
        push_scores(pattern_scores(0));

        // Zero counts behave as one
        drain_results();
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, '0);
        push_scores(pattern_scores(1));

        // 3 x 4 matrix, then shrink the columns to 2 with the cursor at column 3
        drain_results();
        write_reg(REG_ROW_COUNT, 11'd3);
        write_reg(REG_COL_COUNT, 11'd4);
        for (int k = 0; k < 7; k++) begin
            push_scores(pattern_scores(k));
        end
        drain_results();
        write_reg(REG_COL_COUNT, 11'd2);
        // finish the shrunk matrix and wrap to its first word, then walk to row 2
        for (int k = 7; k < 13; k++) begin
            push_scores(pattern_scores(k));
        end
        // drop the row count under the cursor so it falls back to row 0
        drain_results();
        write_reg(REG_ROW_COUNT, 11'd2);
        for (int k = 13; k < 15; k++) begin
            push_scores(pattern_scores(k));
        end

        // Widest matrix: one full row of 1024 columns, then into the second row
        drain_results();
        write_reg(REG_ROW_COUNT, 11'd1024);
        write_reg(REG_COL_COUNT, 11'd2047);
        repeat (BIG_CELLS) begin
            push_scores(random_scores());
        end

        // Random phases: new counts, then whole matrices or a cut-short run
        while (cells_sent < TOTAL_CELLS) begin
            drain_results();
            rows_val = pick_count();
            cols_val = pick_count();
            write_reg(REG_ROW_COUNT, rows_val);
            write_reg(REG_COL_COUNT, cols_val);
            rows_eff = (rows_val == 0) ? 1 : (rows_val > 1024) ? 1024 : int'(rows_val);
            cols_eff = (cols_val == 0) ? 1 : (cols_val > 1024) ? 1024 : int'(cols_val);
            area = rows_eff * cols_eff;
            if (area > 200) begin
                burst = $urandom_range(5, 60);
            end else begin
                burst = area * $urandom_range(1, 3);
                if ($urandom_range(3) == 0) begin
                    burst -= $urandom_range(area - 1);
                end
            end
            if (burst > TOTAL_CELLS - cells_sent) begin
                burst = TOTAL_CELLS - cells_sent;
            end
            repeat (burst) begin
                push_scores(random_scores());
            end
        end

        drain_results();
        if (mismatches == 0 && words_in_flight == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
